// ===== hdl/rie_pkg.sv =====
// Shared types and constants for the integer execute subset unit.
package rie_pkg;

    localparam int unsigned REG_COUNT  = 16;
    localparam int unsigned REG_IDX_W  = 4;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned OP_W       = 5;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned S_TDATA_W  = 56;
    localparam int unsigned M_TDATA_W  = 72;

    localparam logic [DATA_W-1:0] C_ADDR_ALIGN = 32'hffff_fffc;
    localparam logic [DATA_W-1:0] C_BYTE_MASK  = 32'h0000_00ff;
    localparam logic [DATA_W-1:0] C_PC_STEP    = 32'h0000_0004;

    typedef enum logic [OP_W-1:0] {
        OP_MOV     = 5'd0,
        OP_MOVI    = 5'd1,
        OP_MOVA    = 5'd2,
        OP_ADD     = 5'd3,
        OP_ADDI    = 5'd4,
        OP_DT      = 5'd5,
        OP_EXTUB   = 5'd6,
        OP_MULL    = 5'd7,
        OP_NEG     = 5'd8,
        OP_SUB     = 5'd9,
        OP_AND     = 5'd10,
        OP_XOR     = 5'd11,
        OP_SHLL2   = 5'd12,
        OP_SHLL8   = 5'd13,
        OP_SHLL16  = 5'd14,
        OP_SHLR    = 5'd15,
        OP_SHLR2   = 5'd16,
        OP_SHLR16  = 5'd17,
        OP_BF      = 5'd18,
        OP_BFS     = 5'd19,
        OP_BRA     = 5'd20,
        OP_STSMACL = 5'd21,
        OP_LDSFPUL = 5'd22,
        OP_STSFPUL = 5'd23,
        OP_NOP     = 5'd24
    } t_op;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    val;
    } t_wb;

    typedef struct packed {
        logic [DATA_W-1:0]    branch_target;
        logic                 branch_delayed;
        logic                 branch_taken;
        logic                 t_flag;
        logic [DATA_W-1:0]    reg_value;
        logic [REG_IDX_W-1:0] reg_index;
        logic                 reg_write;
    } t_result;

endpackage

// ===== hdl/rie_regfile.sv =====
// General register file with reset valid bits and write-to-read forwarding.
module rie_regfile import rie_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [REG_IDX_W-1:0] i_rd_n,
    input  logic [REG_IDX_W-1:0] i_rd_m,
    input  t_wb                  i_wb,
    output logic [DATA_W-1:0]    o_rn,
    output logic [DATA_W-1:0]    o_rm
);

    logic [DATA_W-1:0]   r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;
    logic [DATA_W-1:0]   r_rn;
    logic [DATA_W-1:0]   r_rm;

    always_ff @(posedge i_clk) begin
        if (i_wb.en) begin
            r_mem[i_wb.idx] <= i_wb.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wb.en) begin
            r_valid[i_wb.idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wb.en && (i_wb.idx == i_rd_n)) begin
                r_rn <= i_wb.val;
            end else if (r_valid[i_rd_n]) begin
                r_rn <= r_mem[i_rd_n];
            end else begin
                r_rn <= '0;
            end
            if (i_wb.en && (i_wb.idx == i_rd_m)) begin
                r_rm <= i_wb.val;
            end else if (r_valid[i_rd_m]) begin
                r_rm <= r_mem[i_rd_m];
            end else begin
                r_rm <= '0;
            end
        end
    end

    assign o_rn = r_rn;
    assign o_rm = r_rm;

endmodule

// ===== hdl/rie_exec.sv =====
// Execute logic with T, MACL and FPUL state.
module rie_exec import rie_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  t_op               i_op,
    input  logic [WORD_W-1:0] i_word,
    input  logic [DATA_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_rn,
    input  logic [DATA_W-1:0] i_rm,
    output t_result           o_res
);

    logic              r_t;
    logic [DATA_W-1:0] r_macl;
    logic [DATA_W-1:0] r_fpul;
    logic              n_t;
    logic [DATA_W-1:0] n_macl;
    logic [DATA_W-1:0] n_fpul;

    logic [REG_IDX_W-1:0] idx_n;
    logic [7:0]           disp;
    logic [DATA_W-1:0]    sdisp;
    logic [DATA_W-1:0]    dec;
    logic [DATA_W-1:0]    pc_next;

    assign idx_n   = i_word[11:8];
    assign disp    = i_word[7:0];
    assign sdisp   = {{24{disp[7]}}, disp};
    assign dec     = i_rn - 32'd1;
    assign pc_next = i_addr + C_PC_STEP;

    always_comb begin
        o_res  = '0;
        n_t    = r_t;
        n_macl = r_macl;
        n_fpul = r_fpul;
        case (i_op)
            OP_MOV: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n; o_res.reg_value = i_rm;
            end
            OP_MOVI: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n; o_res.reg_value = sdisp;
            end
            OP_MOVA: begin
                o_res.reg_write = 1'b1;
                o_res.reg_value = {22'd0, disp, 2'b00} + (i_addr & C_ADDR_ALIGN) + C_PC_STEP;
            end
            OP_ADD: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n; o_res.reg_value = i_rn + i_rm;
            end
            OP_ADDI: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n; o_res.reg_value = i_rn + sdisp;
            end
            OP_DT: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n; o_res.reg_value = dec;
                n_t = (dec == '0);
            end
            OP_EXTUB: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n;
                o_res.reg_value = i_rm & C_BYTE_MASK;
            end
            OP_MULL: begin
                n_macl = i_rn * i_rm;
            end
            OP_NEG: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n; o_res.reg_value = '0 - i_rm;
            end
            OP_SUB: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n; o_res.reg_value = i_rn - i_rm;
            end
            OP_AND: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n; o_res.reg_value = i_rn & i_rm;
            end
            OP_XOR: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n; o_res.reg_value = i_rn ^ i_rm;
            end
            OP_SHLL2: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n; o_res.reg_value = i_rn << 2;
            end
            OP_SHLL8: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n; o_res.reg_value = i_rn << 8;
            end
            OP_SHLL16: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n; o_res.reg_value = i_rn << 16;
            end
            OP_SHLR: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n; o_res.reg_value = i_rn >> 1;
                n_t = i_rn[0];
            end
            OP_SHLR2: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n; o_res.reg_value = i_rn >> 2;
            end
            OP_SHLR16: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n; o_res.reg_value = i_rn >> 16;
            end
            OP_BF, OP_BFS: begin
                if (!r_t) begin
                    o_res.branch_taken   = 1'b1;
                    o_res.branch_delayed = (i_op == OP_BFS);
                    o_res.branch_target  = pc_next + {sdisp[DATA_W-2:0], 1'b0};
                end
            end
            OP_BRA: begin
                o_res.branch_taken   = 1'b1;
                o_res.branch_delayed = 1'b1;
                o_res.branch_target  = pc_next + {{19{i_word[11]}}, i_word[11:0], 1'b0};
            end
            OP_STSMACL: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n; o_res.reg_value = r_macl;
            end
            OP_LDSFPUL: begin
                n_fpul = i_rn;
            end
            OP_STSFPUL: begin
                o_res.reg_write = 1'b1; o_res.reg_index = idx_n; o_res.reg_value = r_fpul;
            end
            default: begin
            end
        endcase
        o_res.t_flag = n_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t    <= 1'b0;
            r_macl <= '0;
            r_fpul <= '0;
        end else if (i_go) begin
            r_t    <= n_t;
            r_macl <= n_macl;
            r_fpul <= n_fpul;
        end
    end

endmodule

// ===== hdl/risc_integer_execute_subset_unit.sv =====
// Top level of the integer execute subset unit.
// Path: operands are read into a registered stage, then executed into the output register.
// Throughput: one beat per cycle while m_tready keeps the output flowing; operands forwarded from the item ahead.
// Output register holds a result during a stall; input taken while a result waits only if the operand stage is empty.
// Synchronous active-low reset clears T, MACL, FPUL, the register valid bits and the stage valid flags.
module risc_integer_execute_subset_unit import rie_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // operation, instr_word, instr_addr
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // reg_write, reg_index, reg_value, t_flag, branch_taken, branch_delayed, branch_target
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic              r_s1_valid;
    t_op               r_s1_op;
    logic [WORD_W-1:0] r_s1_word;
    logic [DATA_W-1:0] r_s1_addr;
    logic              r_out_valid;
    t_result           r_out;

    logic              s1_adv;
    logic              in_acc;
    logic              ex_go;
    logic [DATA_W-1:0] rn;
    logic [DATA_W-1:0] rm;
    t_result           res;
    t_wb               wb;

    assign s1_adv   = !r_out_valid || m_tready;
    assign s_tready = !r_s1_valid || s1_adv;
    assign in_acc   = s_tvalid && s_tready;
    assign ex_go    = r_s1_valid && s1_adv;

    assign wb.en  = ex_go && res.reg_write;
    assign wb.idx = res.reg_index;
    assign wb.val = res.reg_value;

    rie_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (in_acc),
        .i_rd_n  (s_tdata[16:13]),
        .i_rd_m  (s_tdata[12:9]),
        .i_wb    (wb),
        .o_rn    (rn),
        .o_rm    (rm)
    );

    rie_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (ex_go),
        .i_op    (r_s1_op),
        .i_word  (r_s1_word),
        .i_addr  (r_s1_addr),
        .i_rn    (rn),
        .i_rm    (rm),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_tready) begin
            r_s1_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op   <= t_op'(s_tdata[4:0]);
            r_s1_word <= s_tdata[20:5];
            r_s1_addr <= s_tdata[52:21];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ex_go) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out;

`ifndef SYNTH
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> s_tready)
        else $error("input stalled with empty operand stage");

    a_no_write_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !r_out.reg_write) |-> (r_out.reg_index == '0 && r_out.reg_value == '0))
        else $error("write fields set without register write");

    a_no_branch_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !r_out.branch_taken)
            |-> (!r_out.branch_delayed && r_out.branch_target == '0))
        else $error("branch fields set without branch");

    a_exec_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ex_go |=> m_tvalid)
        else $error("executed item did not reach output register");
`endif

endmodule
